@@ design/rt_pkg.sv @@
`default_nettype none
package rt_pkg;
   localparam int SLOTS        = 16;
   localparam int HEADER_BYTES = 16;
   localparam int KEY_BYTES    = 8;
   localparam int CNT_W        = $clog2(SLOTS + 1);
   localparam logic [15:0] PERIOD_RESET = 16'd100;

   typedef enum logic [1:0] {
      OP_PUSH, OP_TICK, OP_FIND, OP_FIND_REMOVE
   } op_type;

   typedef enum logic [2:0] {
      K_PUSHED, K_FULL, K_RESEND, K_EXPIRED, K_FOUND, K_FOUND_REMOVED, K_NOT_FOUND,
      K_TICK_DONE
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_PASS, ST_DONE
   } state_type;

   typedef struct packed {
      logic [63:0] bytes_lo;
      logic [63:0] bytes_hi;
      logic [15:0] handle;
      logic [7:0]  retries;
      logic [15:0] countdown;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef struct packed {
      logic     keep;
      logic     emit;
      logic     match;
      kind_type kind;
   } head_res_type;
endpackage
`default_nettype wire

@@ design/rt_cell.sv @@
`default_nettype none
module rt_cell
   import rt_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire entry_type    neighbor,
   input  wire entry_type    load_data,
   output entry_type         entry
);
   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      if (ctl.load) begin
         entry_in = load_data;
      end else if (ctl.shift) begin
         entry_in = neighbor;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

@@ design/rt_head.sv @@
`default_nettype none
module rt_head
   import rt_pkg::*;
(
   input  wire entry_type   head,
   input  wire op_type      op,
   input  wire logic [63:0] key,
   input  wire logic [3:0]  key_len,
   input  wire logic [3:0]  start,
   input  wire logic [15:0] period,
   input  wire logic        find_done,
   output entry_type        updated,
   output head_res_type     res
);
   logic [127:0] hdr;
   logic [3:0]   len;
   logic         fits;
   logic         eq;
   logic [3:0]   pos;
   logic [15:0]  cd_dec;
   logic [7:0]   rt_dec;

   always_comb begin
      hdr    = {head.bytes_hi, head.bytes_lo};
      len    = (key_len > 4'd8) ? 4'd8 : key_len;
      fits   = ({1'b0, start} + {1'b0, len}) <= 5'(HEADER_BYTES);
      eq     = 1'b1;
      pos    = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         pos = start + 4'(i);
         if ((4'(i) < len) && (hdr[pos*8 +: 8] != key[i*8 +: 8])) begin
            eq = 1'b0;
         end
      end
      cd_dec  = head.countdown - 16'd1;
      rt_dec  = head.retries - 8'd1;
      updated = head;
      res     = '{keep: 1'b1, emit: 1'b0, match: 1'b0, kind: K_RESEND};
      case (op)
         OP_TICK: begin
            if ((head.retries != 8'd0) && (head.countdown != 16'd0)) begin
               if (cd_dec == 16'd0) begin
                  updated.countdown = period;
                  updated.retries   = rt_dec;
                  res.emit          = 1'b1;
                  if (rt_dec == 8'd0) begin
                     res.kind = K_EXPIRED;
                     res.keep = 1'b0;
                  end
               end else begin
                  updated.countdown = cd_dec;
               end
            end
         end
         OP_FIND, OP_FIND_REMOVE: begin
            if (!find_done && fits && eq) begin
               res.match = 1'b1;
               res.keep  = (op != OP_FIND_REMOVE);
            end
         end
         default: begin
         end
      endcase
   end
endmodule
`default_nettype wire

@@ design/retransmit_table.sv @@
// Push: the result is registered in the cycle after the beat is taken; the next
// beat may follow at once. Tick and find: each held entry passes through the head
// evaluator once, then a closing result is issued, and no new beat is taken until
// the closing result has been issued. The entry row rotates through the head
// evaluator once per tick or find. Output stalls pause the rotation and hold off
// new beats. Reset (synchronous): table empty, resend period 100, no result
// pending.
`default_nettype none
module retransmit_table
   import rt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // head_lo, head_hi, packet_id, repeat_count, first_timeout, key, key_len, start_index
   input  wire logic [239:0] req_tdata,
   // op
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // result_id, entries_held, zero fill
   output logic [23:0]       rsp_tdata,
   // kind
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data
);
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   op_type           op_ff, op_in;
   logic [63:0]      key_ff, key_in;
   logic [3:0]       len_ff, len_in;
   logic [3:0]       start_ff, start_in;
   logic [15:0]      period_ff;
   logic             found_ff, found_in;
   logic [15:0]      found_id_ff, found_id_in;
   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         rsp_kind_ff, rsp_kind_in;
   logic [15:0]      rsp_id_ff, rsp_id_in;
   logic [CNT_W-1:0] rsp_held_ff, rsp_held_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             slot_free, accept, step, push_wr, emit;
   op_type           req_op;
   entry_type        push_entry, upd, load_data;
   head_res_type     hres;
   logic [CNT_W-1:0] count_step;
   entry_type        cell_q [SLOTS];
   cell_ctl_type     ctl [SLOTS];

   assign req_op     = op_type'(req_tuser);
   assign push_entry = '{bytes_lo: req_tdata[63:0], bytes_hi: req_tdata[127:64],
                         handle: req_tdata[143:128], retries: req_tdata[151:144],
                         countdown: req_tdata[167:152]};
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign step       = (state_ff == ST_PASS) && slot_free;
   assign push_wr    = accept && (req_op == OP_PUSH) && (count_ff < CNT_W'(SLOTS));
   assign count_step = hres.keep ? count_ff : count_ff - CNT_W'(1);
   assign load_data  = step ? upd : push_entry;

   rt_head u_head (
      .head      (cell_q[0]),
      .op        (op_ff),
      .key       (key_ff),
      .key_len   (len_ff),
      .start     (start_ff),
      .period    (period_ff),
      .find_done (found_ff),
      .updated   (upd),
      .res       (hres)
   );

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      assign ctl[g].shift = step;
      assign ctl[g].load  = (step && hres.keep && (CNT_W'(g) == count_ff - CNT_W'(1)))
                          || (push_wr && (CNT_W'(g) == count_ff));
      rt_cell u_cell (
         .clock     (clock),
         .ctl       (ctl[g]),
         .neighbor  (cell_q[(g < SLOTS - 1) ? g + 1 : g]),
         .load_data (load_data),
         .entry     (cell_q[g])
      );
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rem_in      = rem_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      len_in      = len_ff;
      start_in    = start_ff;
      found_in    = found_ff;
      found_id_in = found_id_ff;
      emit        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_held_in = rsp_held_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               key_in   = req_tdata[231:168];
               len_in   = req_tdata[235:232];
               start_in = req_tdata[239:236];
               found_in = 1'b0;
               rem_in   = count_ff;
               if (req_op == OP_PUSH) begin
                  emit        = 1'b1;
                  rsp_last_in = 1'b1;
                  if (push_wr) begin
                     count_in    = count_ff + CNT_W'(1);
                     rsp_kind_in = K_PUSHED;
                     rsp_id_in   = push_entry.handle;
                     rsp_held_in = count_ff + CNT_W'(1);
                  end else begin
                     rsp_kind_in = K_FULL;
                     rsp_id_in   = '0;
                     rsp_held_in = count_ff;
                  end
               end else if (count_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            if (step) begin
               rem_in   = rem_ff - CNT_W'(1);
               count_in = count_step;
               if (hres.emit) begin
                  emit        = 1'b1;
                  rsp_kind_in = hres.kind;
                  rsp_id_in   = cell_q[0].handle;
                  rsp_held_in = count_step;
                  rsp_last_in = 1'b0;
               end
               if (hres.match) begin
                  found_in    = 1'b1;
                  found_id_in = cell_q[0].handle;
               end
               if (rem_ff == CNT_W'(1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               emit        = 1'b1;
               rsp_held_in = count_ff;
               rsp_last_in = 1'b1;
               if (op_ff == OP_TICK) begin
                  rsp_kind_in = K_TICK_DONE;
                  rsp_id_in   = '0;
               end else if (found_ff) begin
                  rsp_kind_in = (op_ff == OP_FIND_REMOVE) ? K_FOUND_REMOVED : K_FOUND;
                  rsp_id_in   = found_id_ff;
               end else begin
                  rsp_kind_in = K_NOT_FOUND;
                  rsp_id_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= PERIOD_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      len_ff      <= len_in;
      start_ff    <= start_in;
      found_id_ff <= found_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_held_ff <= rsp_held_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_held_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("entry count above table size");
   a_pass_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS) |-> ((rem_ff != '0) && (rem_ff <= count_ff)))
      else $error("rotation counter out of range");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push_wr |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not grow table");
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == ST_IDLE))
      else $error("beat taken while busy");
`endif
endmodule
`default_nettype wire
